### hw/rtl/ucd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// Used by the controller, the datapath and the top level.
package ucd_pkg;

	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int WIN_LEN  = 4;
	localparam int COUNT_W  = 3;

	localparam logic [CP_W-1:0] INVALID_CODE = CP_W'(63);

	typedef logic [WIN_LEN-1:0][BYTE_W-1:0] window_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            run_last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic   emit;
		logic   last;
		logic   out_free;
		count_t count;
	} status_t;

endpackage

### hw/rtl/ucd_stream_if.sv
// Valid/ready stream channel carrying one request payload.
// The payload type is set per instance; no package dependency.
interface ucd_stream_if #(parameter type payload_t = logic [7:0]) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ucd_datapath.sv
// Datapath of the UTF-8 decoder: byte window, lead byte evaluation and result register.
// Depends on ucd_pkg; driven by commands from ucd_ctrl.
module ucd_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ucd_pkg::cmd_t     cmd,
	input  ucd_pkg::in_item_t in_item,
	input  logic              out_ready,
	output logic              out_valid,
	output ucd_pkg::out_item_t out_item,
	output ucd_pkg::status_t  status
);
	import ucd_pkg::*;

	typedef struct packed {
		logic            emit;
		count_t          consume;
		logic [CP_W-1:0] cp;
	} eval_t;

	function automatic eval_t eval_lead(window_t w, count_t n, logic flush);
		eval_t            r;
		logic [1:0]       need;
		logic             missing;
		logic             bad;
		logic             done;
		logic [BYTE_W-1:0] b;
		r       = '0;
		b       = w[0];
		need    = 2'd0;
		missing = 1'b0;
		bad     = 1'b0;
		done    = 1'b0;
		priority if (b[7:5] == 3'b110) need = 2'd1;
		else if (b[7:4] == 4'b1110) need = 2'd2;
		else if (b[7:3] == 5'b11110) need = 2'd3;
		else need = 2'd0;
		for (int k = 1; k < WIN_LEN; k++) begin
			if (!done && (2'(k) <= need)) begin
				if (COUNT_W'(k) >= n) begin
					missing = 1'b1;
					done    = 1'b1;
				end else if (w[k][7:6] != 2'b10) begin
					bad  = 1'b1;
					done = 1'b1;
				end
			end
		end
		if (n == '0) begin
			r.emit = 1'b0;
		end else if (!b[7]) begin
			r.emit    = 1'b1;
			r.consume = COUNT_W'(1);
			r.cp      = CP_W'(b);
		end else if (need == 2'd0 || bad || (missing && flush)) begin
			r.emit    = 1'b1;
			r.consume = COUNT_W'(1);
			r.cp      = INVALID_CODE;
		end else if (missing) begin
			r.emit = 1'b0;
		end else begin
			r.emit    = 1'b1;
			r.consume = {1'b0, need} + COUNT_W'(1);
			unique case (need)
				2'd1: r.cp = {10'd0, b[4:0], w[1][5:0]};
				2'd2: r.cp = {5'd0, b[3:0], w[1][5:0], w[2][5:0]};
				default: r.cp = {b[2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
			endcase
		end
		return r;
	endfunction

	function automatic window_t shift_win(window_t w, count_t c);
		window_t    r;
		logic [3:0] idx;
		for (int i = 0; i < WIN_LEN; i++) begin
			idx = 4'(i) + {1'b0, c};
			r[i] = (idx < 4'(WIN_LEN)) ? w[idx[1:0]] : '0;
		end
		return r;
	endfunction

	window_t         win_q;
	count_t          count_q;
	logic            flush_q;
	logic            out_valid_q;
	out_item_t       out_q;

	eval_t           cur;
	eval_t           nxt;
	window_t         win_next;
	count_t          count_next;
	logic            in_nonzero;

	assign in_nonzero = (in_item.text_byte != '0);
	assign cur        = eval_lead(win_q, count_q, flush_q);
	assign win_next   = shift_win(win_q, cur.consume);
	assign count_next = count_q - cur.consume;
	assign nxt        = eval_lead(win_next, count_next, flush_q);

	assign status.emit     = cur.emit;
	assign status.last     = (count_next == '0) || !nxt.emit;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.count    = count_q;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= count_q + COUNT_W'(in_nonzero);
				flush_q <= in_item.end_of_text || !in_nonzero;
			end else if (cmd.step) begin
				count_q <= count_next;
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_nonzero) begin
			win_q[count_q[1:0]] <= in_item.text_byte;
		end else if (cmd.step) begin
			win_q <= win_next;
		end
		if (cmd.step) begin
			out_q.code_point <= cur.cp;
			out_q.run_last   <= status.last;
		end
	end

endmodule

### hw/rtl/ucd_ctrl.sv
// Controller of the UTF-8 decoder: takes a byte request, then steps the datapath once per result.
// Depends on ucd_pkg; commands ucd_datapath and reads its status.
module ucd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ucd_pkg::status_t status,
	output ucd_pkg::cmd_t    cmd
);
	import ucd_pkg::*;

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == IDLE);
	assign cmd.load = in_ready && in_valid;
	assign cmd.step = (state_q == RUN) && status.emit && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= RUN;
				end
				RUN: begin
					if (!status.emit) state_q <= IDLE;
					else if (status.out_free && status.last) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/utf8_codepoint_decoder_core.sv
// UTF-8 code point decoder: one byte request in, zero to four code point requests out.
// A byte is taken while the controller is idle, then decoded one result per cycle while the
// output can take a result: the controller steps one lead byte per cycle and holds while the
// result register is full. The byte is loaded into the window, then a step fills the result register.
// Asynchronous active-low reset empties the held sequence and the result register.
module utf8_codepoint_decoder_core (
	input  logic         clk,
	input  logic         arst_n,
	ucd_stream_if.sink   text,
	ucd_stream_if.source points
);
	import ucd_pkg::*;

	cmd_t      cmd;
	status_t   status;
	in_item_t  in_item;
	out_item_t out_item;
	logic      out_valid;

	assign in_item.text_byte   = text.data.text_byte;
	assign in_item.end_of_text = text.data.end_of_text;

	ucd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ucd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.out_ready (points.ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.status    (status)
	);

	assign points.valid           = out_valid;
	assign points.data.code_point = out_item.code_point;
	assign points.data.run_last   = out_item.run_last;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready) |=> !text.ready)
		else $error("byte request accepted while previous byte still in progress");

	a_held_fits: assert property (@(posedge clk) disable iff (!arst_n)
		text.ready |-> (status.count <= COUNT_W'(3)))
		else $error("more than three bytes held between byte requests");

	a_load_step_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.step)
		else $error("window loaded and stepped in the same cycle");

endmodule
